// ===== sv/mm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mm_pkg: shared types and codes of the matrix multiply core
// Item kinds, register indexes and the control word passed along the cell chain.
// ----------------------------------------------------------------------------
package mm_pkg;

	localparam logic [1:0] KIND_LEFT  = 2'd0;
	localparam logic [1:0] KIND_RIGHT = 2'd1;
	localparam logic [1:0] KIND_START = 2'd2;

	localparam logic [1:0] CFG_LEFT_ROWS  = 2'd0;
	localparam logic [1:0] CFG_INNER_SIZE = 2'd1;
	localparam logic [1:0] CFG_RIGHT_COLS = 2'd2;

	typedef struct packed {
		logic valid;
		logic first;
	} mm_ctl_t;

endpackage
`default_nettype wire

// ===== sv/mm_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mm_cmd_if / mm_res_if: valid-ready channels of the matrix multiply core
// Command items in, product entries out.
// ----------------------------------------------------------------------------
interface mm_cmd_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [2:0]         row;
	logic [2:0]         col;
	logic signed [31:0] value;
	modport src (output valid, kind, row, col, value, input ready);
	modport snk (input valid, kind, row, col, value, output ready);
endinterface

interface mm_res_if;
	logic               valid;
	logic               ready;
	logic [2:0]         out_row;
	logic [2:0]         out_col;
	logic signed [31:0] product;
	logic               saturated;
	logic               last;
	modport src (output valid, out_row, out_col, product, saturated, last, input ready);
	modport snk (input valid, out_row, out_col, product, saturated, last, output ready);
endinterface
`default_nettype wire

// ===== sv/mm_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mm_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module mm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// ===== sv/mm_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mm_cell: one column cell of the product chain
// Holds one column of the right matrix, multiplies the passing left element
// by its entry and accumulates; accumulators shift toward the head to unload.
// ----------------------------------------------------------------------------
module mm_cell #(
	parameter int MAX_DIM = 8,
	parameter int AW      = 67
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic signed [31:0]         a_in,
	input  wire mm_pkg::mm_ctl_t            ctl_in,
	input  wire logic [$clog2(MAX_DIM)-1:0] k_in,
	output logic signed [31:0]              a_out,
	output mm_pkg::mm_ctl_t                 ctl_out,
	output logic [$clog2(MAX_DIM)-1:0]      k_out,
	input  wire logic                       we,
	input  wire logic [$clog2(MAX_DIM)-1:0] waddr,
	input  wire logic [31:0]                wdata,
	input  wire logic                       shift,
	input  wire logic [AW-1:0]              acc_next,
	output logic [AW-1:0]                   acc
);
	localparam int IDX_W = $clog2(MAX_DIM);

	logic [31:0]           b_s1;
	logic signed [31:0]    a_s1;
	logic [IDX_W-1:0]      k_s1;
	mm_pkg::mm_ctl_t       ctl_s1;
	mm_pkg::mm_ctl_t       ctl_s2;
	logic signed [63:0]    prod_s2;
	logic [AW-1:0]         acc_q;
	logic [AW-1:0]         prod_ext;

	mm_ram #(.WIDTH(32), .DEPTH(MAX_DIM)) u_bank (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(k_in),
		.rdata(b_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		a_s1    <= a_in;
		k_s1    <= k_in;
		prod_s2 <= a_s1 * $signed(b_s1);
	end

	assign prod_ext = AW'(prod_s2);

	// clear on the first term of an entry, shift only while unloading
	always_ff @(posedge clk) begin
		if (ctl_s2.valid) begin
			acc_q <= ctl_s2.first ? prod_ext : acc_q + prod_ext;
		end else if (shift) begin
			acc_q <= acc_next;
		end
	end

	assign a_out   = a_s1;
	assign ctl_out = ctl_s1;
	assign k_out   = k_s1;
	assign acc     = acc_q;
endmodule
`default_nettype wire

// ===== sv/matrix_multiply_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_multiply_core: fixed-point matrix product engine
// Load left/right Q16.16 elements, then stream out the rounded, saturated
// product in row-major order.
// ----------------------------------------------------------------------------
// Load items are accepted back to back while idle. A start item
// computes the product one output row at a time: the row of the left matrix is
// read from its RAM one element per cycle and passed down a chain of MAX_DIM
// cells, each holding one column of the right matrix and accumulating one
// entry at full width. Each row is fed as inner_size elements, the chain then
// drains, then right_cols entries are unloaded (one entry per cycle while
// the result channel is ready). No item is accepted until the last
// entry of the product has entered the output register. Dimension registers
// of 0 act as 1 and above MAX_DIM act as MAX_DIM; loads outside the store are
// dropped. Reading an element never loaded gives an undefined entry.
module matrix_multiply_core #(
	parameter int MAX_DIM   = 8,
	parameter int FRAC_BITS = 16
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	mm_cmd_if.snk           cmd,
	mm_res_if.src           res,
	input  wire logic       cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [3:0] cfg_data
);
	localparam int IDX_W   = $clog2(MAX_DIM);
	localparam int CNT_W   = $clog2(MAX_DIM + 1);
	localparam int LA_W    = $clog2(MAX_DIM * MAX_DIM);
	localparam int AW      = 64 + IDX_W;
	localparam int DRAIN_N = MAX_DIM + 4;
	localparam int DR_W    = $clog2(DRAIN_N + 1);
	localparam logic [AW:0] HALF = (AW + 1)'((64'(1) << FRAC_BITS) >> 1);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_FEED   = 2'd1;
	localparam logic [1:0] ST_DRAIN  = 2'd2;
	localparam logic [1:0] ST_UNLOAD = 2'd3;

	logic [3:0]       left_rows_q, inner_size_q, right_cols_q;
	logic [1:0]       state_q;
	logic [CNT_W-1:0] rows_q, inner_q, cols_q;
	logic [IDX_W-1:0] i_q, k_q, j_q;
	logic [DR_W-1:0]  drain_q;

	logic             cmd_acc, idx_ok;
	logic [IDX_W-1:0] r_idx, c_idx;
	logic [LA_W-1:0]  lw_addr, lr_addr;
	logic [31:0]      left_rdata;
	mm_pkg::mm_ctl_t  feed_ctl_s1;
	logic [IDX_W-1:0] feed_k_s1;
	logic             take, shift;
	logic             k_last, j_last, i_last;

	logic signed [31:0] a_c   [MAX_DIM+1];
	mm_pkg::mm_ctl_t    ctl_c [MAX_DIM+1];
	logic [IDX_W-1:0]   k_c   [MAX_DIM+1];
	logic [AW-1:0]      acc_c [MAX_DIM+1];

	logic [AW:0]      rsum, rshift;
	logic             in_range;
	logic [31:0]      rval;

	logic             ov_q;
	logic [2:0]       orow_q, ocol_q;
	logic [31:0]      oprod_q;
	logic             osat_q, olast_q;

	function automatic logic [CNT_W-1:0] eff_dim(input logic [3:0] v);
		logic [CNT_W-1:0] r;
		if (v == 4'd0) r = CNT_W'(1);
		else if (32'(v) > MAX_DIM) r = CNT_W'(MAX_DIM);
		else r = CNT_W'(v);
		return r;
	endfunction

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_rows_q  <= 4'd8;
			inner_size_q <= 4'd8;
			right_cols_q <= 4'd8;
		end else if (cfg_we) begin
			case (cfg_index)
				mm_pkg::CFG_LEFT_ROWS:  left_rows_q  <= cfg_data;
				mm_pkg::CFG_INNER_SIZE: inner_size_q <= cfg_data;
				mm_pkg::CFG_RIGHT_COLS: right_cols_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_acc   = cmd.valid && cmd.ready;
	assign idx_ok    = (32'(cmd.row) < MAX_DIM) && (32'(cmd.col) < MAX_DIM);
	assign r_idx     = IDX_W'(cmd.row);
	assign c_idx     = IDX_W'(cmd.col);
	assign lw_addr   = LA_W'(r_idx) * LA_W'(MAX_DIM) + LA_W'(c_idx);
	assign lr_addr   = LA_W'(i_q) * LA_W'(MAX_DIM) + LA_W'(k_q);

	mm_ram #(.WIDTH(32), .DEPTH(MAX_DIM * MAX_DIM)) u_left (
		.clk  (clk),
		.we   (cmd_acc && cmd.kind == mm_pkg::KIND_LEFT && idx_ok),
		.waddr(lw_addr),
		.wdata(cmd.value),
		.raddr(lr_addr),
		.rdata(left_rdata)
	);

	assign k_last = (CNT_W'(k_q) + CNT_W'(1)) == inner_q;
	assign j_last = (CNT_W'(j_q) + CNT_W'(1)) == cols_q;
	assign i_last = (CNT_W'(i_q) + CNT_W'(1)) == rows_q;
	assign take   = (state_q == ST_UNLOAD) && (!ov_q || res.ready);
	assign shift  = take;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rows_q      <= '0;
			inner_q     <= '0;
			cols_q      <= '0;
			i_q         <= '0;
			k_q         <= '0;
			j_q         <= '0;
			drain_q     <= '0;
			feed_ctl_s1 <= '0;
		end else begin
			feed_ctl_s1.valid <= (state_q == ST_FEED);
			feed_ctl_s1.first <= (k_q == '0);
			case (state_q)
				ST_IDLE: begin
					if (cmd_acc && cmd.kind == mm_pkg::KIND_START) begin
						rows_q  <= eff_dim(left_rows_q);
						inner_q <= eff_dim(inner_size_q);
						cols_q  <= eff_dim(right_cols_q);
						i_q     <= '0;
						k_q     <= '0;
						state_q <= ST_FEED;
					end
				end
				ST_FEED: begin
					if (k_last) begin
						k_q     <= '0;
						drain_q <= '0;
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + IDX_W'(1);
					end
				end
				ST_DRAIN: begin
					if (drain_q == DR_W'(DRAIN_N - 1)) begin
						j_q     <= '0;
						state_q <= ST_UNLOAD;
					end else begin
						drain_q <= drain_q + DR_W'(1);
					end
				end
				ST_UNLOAD: begin
					if (take) begin
						if (j_last) begin
							if (i_last) begin
								state_q <= ST_IDLE;
							end else begin
								i_q     <= i_q + IDX_W'(1);
								state_q <= ST_FEED;
							end
						end else begin
							j_q <= j_q + IDX_W'(1);
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		feed_k_s1 <= k_q;
	end

	// cell chain
	assign a_c[0]         = $signed(left_rdata);
	assign ctl_c[0]       = feed_ctl_s1;
	assign k_c[0]         = feed_k_s1;
	assign acc_c[MAX_DIM] = '0;

	for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
		mm_cell #(.MAX_DIM(MAX_DIM), .AW(AW)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.a_in    (a_c[j]),
			.ctl_in  (ctl_c[j]),
			.k_in    (k_c[j]),
			.a_out   (a_c[j+1]),
			.ctl_out (ctl_c[j+1]),
			.k_out   (k_c[j+1]),
			.we      (cmd_acc && cmd.kind == mm_pkg::KIND_RIGHT && idx_ok &&
			          c_idx == IDX_W'(j)),
			.waddr   (r_idx),
			.wdata   (cmd.value),
			.shift   (shift),
			.acc_next(acc_c[j+1]),
			.acc     (acc_c[j])
		);
	end

	// round to nearest, ties up, then clip to 32 bits
	always_comb begin
		rsum     = {acc_c[0][AW-1], acc_c[0]} + HALF;
		rshift   = $signed(rsum) >>> FRAC_BITS;
		in_range = (&rshift[AW:31]) || !(|rshift[AW:31]);
		if (in_range) rval = rshift[31:0];
		else rval = rshift[AW] ? 32'h8000_0000 : 32'h7FFF_FFFF;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (take) begin
			ov_q <= 1'b1;
		end else if (res.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			orow_q  <= 3'(i_q);
			ocol_q  <= 3'(j_q);
			oprod_q <= rval;
			osat_q  <= !in_range;
			olast_q <= i_last && j_last;
		end
	end

	assign res.valid     = ov_q;
	assign res.out_row   = orow_q;
	assign res.out_col   = ocol_q;
	assign res.product   = oprod_q;
	assign res.saturated = osat_q;
	assign res.last      = olast_q;

`ifndef SYNTHESIS
	a_no_cmd_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !cmd.ready)
		else $error("command accepted while product running");
	a_chain_idle_unload: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_UNLOAD) |-> !feed_ctl_s1.valid && !ctl_c[MAX_DIM].valid)
		else $error("chain still busy while unloading");
	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		(take && i_last && j_last) |=> (state_q == ST_IDLE) && res.valid && res.last)
		else $error("final entry not marked");
`endif
endmodule
`default_nettype wire
